// ===== hdl/tgema_pkg.sv =====
// Shared constants, types and codes for the two-channel time-gated moving average.
package tgema_pkg;

    localparam int VALUE_WIDTH     = 48;
    localparam int TIME_WIDTH      = 48;
    localparam int ALPHA_FRAC_BITS = 16;

    localparam int ALPHA_W    = ALPHA_FRAC_BITS + 1;
    localparam int INTERVAL_W = 32;
    localparam int CFG_DATA_W = (ALPHA_W > INTERVAL_W) ? ALPHA_W : INTERVAL_W;
    localparam int CFG_IDX_W  = 1;
    localparam int REQ_W      = 2;

    localparam int DIFF_W = VALUE_WIDTH + 1;
    localparam int AMUL_W = ALPHA_W + 1;
    localparam int PROD_W = DIFF_W + AMUL_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = ALPHA_W'(1) << ALPHA_FRAC_BITS;
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = ALPHA_W'(21845);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(5000000);
    localparam logic [PROD_W-1:0]     ROUND_HALF     = PROD_W'(1) << (ALPHA_FRAC_BITS - 1);

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PRICE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MID   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd1;

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic                   ch;
        logic [VALUE_WIDTH-1:0] sample;
        logic [TIME_WIDTH-1:0]  timestamp;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

// ===== hdl/tgema_in_if.sv =====
// Input channel: request beats with valid/ready handshake.
interface tgema_in_if;
    logic                             valid;
    logic                             ready;
    logic [tgema_pkg::REQ_W-1:0]       req_type;
    logic [tgema_pkg::VALUE_WIDTH-1:0] sample;
    logic [tgema_pkg::TIME_WIDTH-1:0]  timestamp;

    modport source (output valid, output req_type, output sample, output timestamp,
                    input ready);
    modport sink   (input valid, input req_type, input sample, input timestamp,
                    output ready);
endinterface

// ===== hdl/tgema_out_if.sv =====
// Output channel: result beats with valid/ready handshake.
interface tgema_out_if;
    logic                             valid;
    logic                             ready;
    logic [tgema_pkg::VALUE_WIDTH-1:0] ema_value;
    logic                             updated;
    logic                             initialized;

    modport source (output valid, output ema_value, output updated, output initialized,
                    input ready);
    modport sink   (input valid, input ema_value, input updated, input initialized,
                    output ready);
endinterface

// ===== hdl/tgema_front.sv =====
// Front end: accept request beats, classify them and hold them in a short queue.
module tgema_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tgema_in_if.sink               i_in,
    input  logic                   i_pop,
    output tgema_pkg::t_queue_head o_head
);

    tgema_pkg::t_item                    r_mem [tgema_pkg::QUEUE_DEPTH];
    logic [tgema_pkg::PTR_W-1:0]         r_wr_ptr;
    logic [tgema_pkg::PTR_W-1:0]         r_rd_ptr;
    logic [tgema_pkg::CNT_W-1:0]         r_count;
    logic [tgema_pkg::PTR_W-1:0]         n_wr_ptr;
    logic [tgema_pkg::PTR_W-1:0]         n_rd_ptr;
    logic [tgema_pkg::CNT_W-1:0]         n_count;
    tgema_pkg::t_item                    w_item;
    logic                                w_push;
    logic                                w_pop;

    // Classify the incoming request
    always_comb begin
        w_item.ch        = 1'b0;
        w_item.sample    = i_in.sample;
        w_item.timestamp = i_in.timestamp;
        case (i_in.req_type)
            tgema_pkg::REQ_PRICE: begin
                w_item.kind = tgema_pkg::K_SAMPLE;
            end
            tgema_pkg::REQ_MID: begin
                w_item.kind = tgema_pkg::K_SAMPLE;
                w_item.ch   = 1'b1;
            end
            tgema_pkg::REQ_CLEAR: begin
                w_item.kind = tgema_pkg::K_CLEAR;
            end
            default: begin
                w_item.kind = tgema_pkg::K_NOP;
            end
        endcase
    end

    assign i_in.ready = (r_count != tgema_pkg::CNT_W'(tgema_pkg::QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == tgema_pkg::PTR_W'(tgema_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == tgema_pkg::PTR_W'(tgema_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

// ===== hdl/tgema_back.sv =====
// Back end: channel state, gated blend update, configuration registers and output register.
module tgema_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tgema_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tgema_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  tgema_pkg::t_queue_head             i_head,
    output logic                               o_pop,
    tgema_out_if.source                        o_out
);

    logic [tgema_pkg::ALPHA_W-1:0]     r_alpha;
    logic [tgema_pkg::INTERVAL_W-1:0]  r_interval;
    logic [tgema_pkg::VALUE_WIDTH-1:0] r_avg  [2];
    logic                              r_seen [2];
    logic [tgema_pkg::TIME_WIDTH-1:0]  r_last [2];

    logic                              r_out_valid;
    logic [tgema_pkg::VALUE_WIDTH-1:0] r_out_ema;
    logic                              r_out_upd;
    logic                              r_out_init;
    logic [tgema_pkg::VALUE_WIDTH-1:0] n_out_ema;
    logic                              n_out_upd;
    logic                              n_out_init;

    logic                                w_advance;
    logic                                w_ch;
    logic [tgema_pkg::ALPHA_W-1:0]       w_alpha_eff;
    logic [tgema_pkg::VALUE_WIDTH-1:0]   w_avg_cur;
    logic [tgema_pkg::TIME_WIDTH-1:0]    w_last_cur;
    logic [tgema_pkg::TIME_WIDTH:0]      w_gap;
    logic                                w_gap_ok;
    logic signed [tgema_pkg::DIFF_W-1:0] w_diff;
    logic signed [tgema_pkg::PROD_W-1:0] w_prod;
    logic [tgema_pkg::PROD_W-1:0]        w_prod_rnd;
    logic [tgema_pkg::VALUE_WIDTH-1:0]   w_step;
    logic [tgema_pkg::VALUE_WIDTH-1:0]   w_blended;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= tgema_pkg::ALPHA_RESET;
            r_interval <= tgema_pkg::INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tgema_pkg::CFG_ALPHA: begin
                    r_alpha <= i_cfg_data[tgema_pkg::ALPHA_W-1:0];
                end
                tgema_pkg::CFG_INTERVAL: begin
                    r_interval <= i_cfg_data[tgema_pkg::INTERVAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Take the queue head whenever the output register is empty or drains this cycle
    assign w_advance = i_head.valid && (!r_out_valid || o_out.ready);
    assign o_pop     = w_advance;

    // Blend as ema + a*(x - ema), rounded half up; saturate alpha at one
    always_comb begin
        w_ch        = i_head.item.ch;
        w_alpha_eff = r_alpha[tgema_pkg::ALPHA_W-1] ? tgema_pkg::ALPHA_ONE : r_alpha;
        w_avg_cur   = r_avg[w_ch];
        w_last_cur  = r_last[w_ch];
        w_gap       = {1'b0, i_head.item.timestamp} - {1'b0, w_last_cur};
        w_gap_ok    = !w_gap[tgema_pkg::TIME_WIDTH] &&
                      (w_gap[tgema_pkg::TIME_WIDTH-1:0] >= tgema_pkg::TIME_WIDTH'(r_interval));
        w_diff      = $signed({1'b0, i_head.item.sample}) - $signed({1'b0, w_avg_cur});
        w_prod      = w_diff * $signed({1'b0, w_alpha_eff});
        w_prod_rnd  = w_prod + tgema_pkg::ROUND_HALF;
        w_step      = w_prod_rnd[tgema_pkg::ALPHA_FRAC_BITS +: tgema_pkg::VALUE_WIDTH];
        w_blended   = w_avg_cur + w_step;
    end

    always_comb begin
        n_out_ema  = '0;
        n_out_upd  = 1'b0;
        n_out_init = 1'b0;
        case (i_head.item.kind)
            tgema_pkg::K_SAMPLE: begin
                n_out_init = 1'b1;
                if (!r_seen[w_ch]) begin
                    n_out_ema = i_head.item.sample;
                    n_out_upd = 1'b1;
                end else if (w_gap_ok) begin
                    n_out_ema = w_blended;
                    n_out_upd = 1'b1;
                end else begin
                    n_out_ema = w_avg_cur;
                end
            end
            default: begin
            end
        endcase
    end

    // Channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg[0]  <= '0;
            r_avg[1]  <= '0;
            r_seen[0] <= 1'b0;
            r_seen[1] <= 1'b0;
        end else if (w_advance) begin
            if (i_head.item.kind == tgema_pkg::K_CLEAR) begin
                r_avg[0]  <= '0;
                r_avg[1]  <= '0;
                r_seen[0] <= 1'b0;
                r_seen[1] <= 1'b0;
            end else if (i_head.item.kind == tgema_pkg::K_SAMPLE) begin
                r_avg[w_ch]  <= n_out_ema;
                r_seen[w_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && (i_head.item.kind == tgema_pkg::K_SAMPLE) && n_out_upd) begin
            r_last[w_ch] <= i_head.item.timestamp;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_ema  <= n_out_ema;
            r_out_upd  <= n_out_upd;
            r_out_init <= n_out_init;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ema_value   = r_out_ema;
    assign o_out.updated     = r_out_upd;
    assign o_out.initialized = r_out_init;

    a_clear_drops_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (i_head.item.kind == tgema_pkg::K_CLEAR)
        |=> !r_seen[0] && !r_seen[1])
        else $error("seen flag survived a clear");

    a_sample_sets_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (i_head.item.kind == tgema_pkg::K_SAMPLE)
        |=> r_seen[$past(w_ch)])
        else $error("sample did not mark its channel as seen");

    a_upd_implies_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_upd |-> r_out_init)
        else $error("update reported on an uninitialized channel");

    a_uninit_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_init |-> (r_out_ema == '0))
        else $error("nonzero average on an uninitialized result");

endmodule

// ===== hdl/time_gated_ema_two_channel_top.sv =====
// Top level of the two-channel time-gated exponential moving average.
//
//  channel   dir  handshake           payload
//  i_in      in   valid/ready         req_type[1:0], sample[47:0], timestamp[47:0]
//  o_out     out  valid/ready         ema_value[47:0], updated, initialized
//  cfg       in   i_cfg_we (no wait)  i_cfg_idx (0 alpha, 1 interval_us), i_cfg_data[31:0]
//
//  One request beat per cycle sustained while the output is ready, one result beat per
//  request. The rate is set by the per-channel update loop: read the average, one 49x18
//  signed multiply, round, add and write back, all combinational within the back end.
//  An input beat passes through the queue, then the output register, to become a result beat.
//  Reset is synchronous, active low: averages and seen flags clear at once, no sweep.
//  A stalled output holds its beat; the two-entry queue keeps taking input until full.
module time_gated_ema_two_channel_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tgema_in_if.sink                         i_in,
    tgema_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [tgema_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tgema_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Queue head and its pop strobe between front and back
    tgema_pkg::t_queue_head w_head;
    logic                   w_pop;

    // Accept and classify request beats, buffer them
    tgema_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Apply each request to the channel state and present the result beat
    tgema_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule
